>>> hw/rtl/skti_pkg.sv
// Package: shared constants, types and command/status structs for the knot table interpolator.
package skti_pkg;

  localparam int Capacity  = 64;
  localparam int IdxW      = $clog2(Capacity);
  localparam int CntW      = $clog2(Capacity + 1);
  localparam int ProdW     = 66;
  localparam int OpW       = 2;
  localparam int StW       = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT  = 2'd0,
    OP_PREDICT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SRCH_WAIT,
    S_SHIFT,
    S_WRITE,
    S_RD_S,
    S_RD_E,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;       // capture input word
    logic srch_start; // initialise binary search bounds
    logic srch_step;  // compare read key and narrow bounds
    logic shift_wr;   // write it one place up, step pointer down
    logic ins_wr;     // write new knot at insert position
    logic rd_s;       // read lower knot
    logic rd_e;       // read upper knot
    logic setup;      // form differences
    logic mul;        // multiply both dims
    logic div_start;
    logic div_step;
    logic fin;        // round, saturate, build result
    logic clear;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic srch_done;
    logic shift_done;
    logic full;
    logic few;
    logic div_done;
  } sts_t;

endpackage

>>> hw/rtl/skti_ctrl.sv
// Controller state machine sequencing search, shift, interpolation and output.
module skti_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  skti_pkg::sts_t  sts_i,
  output skti_pkg::cmd_t  cmd_o
);

  skti_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skti_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      skti_pkg::S_IDLE: begin
        if (in_valid_i) state_d = skti_pkg::S_SEARCH;
      end
      skti_pkg::S_SEARCH: begin
        case (sts_i.op)
          skti_pkg::OP_INSERT:  state_d = skti_pkg::S_SRCH_WAIT;
          skti_pkg::OP_PREDICT: state_d = sts_i.few ? skti_pkg::S_FIN : skti_pkg::S_SRCH_WAIT;
          default:              state_d = skti_pkg::S_FIN;
        endcase
      end
      skti_pkg::S_SRCH_WAIT: begin
        if (sts_i.srch_done) begin
          if (sts_i.op == skti_pkg::OP_INSERT) begin
            state_d = sts_i.full ? skti_pkg::S_FIN : skti_pkg::S_SHIFT;
          end else begin
            state_d = skti_pkg::S_RD_S;
          end
        end
      end
      skti_pkg::S_SHIFT: begin
        if (sts_i.shift_done) state_d = skti_pkg::S_WRITE;
      end
      skti_pkg::S_WRITE: state_d = skti_pkg::S_FIN;
      skti_pkg::S_RD_S:  state_d = skti_pkg::S_RD_E;
      skti_pkg::S_RD_E:  state_d = skti_pkg::S_SETUP;
      skti_pkg::S_SETUP: state_d = skti_pkg::S_MUL;
      skti_pkg::S_MUL:   state_d = skti_pkg::S_DIV;
      skti_pkg::S_DIV: begin
        if (sts_i.div_done) state_d = skti_pkg::S_FIN;
      end
      skti_pkg::S_FIN:   state_d = skti_pkg::S_OUT;
      skti_pkg::S_OUT: begin
        if (out_ready_i) state_d = skti_pkg::S_IDLE;
      end
      default: state_d = skti_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      skti_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      skti_pkg::S_SEARCH: begin
        cmd_o.srch_start = 1'b1;
        if (sts_i.op == skti_pkg::OP_CLEAR) cmd_o.clear = 1'b1;
      end
      skti_pkg::S_SRCH_WAIT: begin
        cmd_o.srch_step = 1'b1;
      end
      skti_pkg::S_SHIFT: begin
        cmd_o.shift_wr = 1'b1;
      end
      skti_pkg::S_WRITE:  cmd_o.ins_wr = 1'b1;
      skti_pkg::S_RD_S:   cmd_o.rd_s = 1'b1;
      skti_pkg::S_RD_E:   cmd_o.rd_e = 1'b1;
      skti_pkg::S_SETUP:  cmd_o.setup = 1'b1;
      skti_pkg::S_MUL: begin
        cmd_o.mul       = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      skti_pkg::S_DIV:    cmd_o.div_step = 1'b1;
      skti_pkg::S_FIN:    cmd_o.fin = 1'b1;
      skti_pkg::S_OUT:    out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/skti_datapath.sv
// Datapath: knot memories, binary search, shifter, multipliers and serial divider.
module skti_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  skti_pkg::cmd_t               cmd_i,
  output skti_pkg::sts_t               sts_o,
  input  logic [skti_pkg::OpW-1:0]     op_i,
  input  logic signed [31:0]           key_i,
  input  logic signed [31:0]           value0_i,
  input  logic signed [31:0]           value1_i,
  output logic signed [31:0]           out0_o,
  output logic signed [31:0]           out1_o,
  output logic [5:0]                   seg_start_o,
  output logic [5:0]                   seg_end_o,
  output logic [skti_pkg::StW-1:0]     status_o,
  output logic [6:0]                   knot_count_o
);

  localparam int IW = skti_pkg::IdxW;
  localparam int CW = skti_pkg::CntW;
  localparam int PW = skti_pkg::ProdW;
  localparam int DCW = $clog2(PW + 1);

  logic signed [31:0] key_mem [skti_pkg::Capacity];
  logic [63:0]        val_mem [skti_pkg::Capacity];

  skti_pkg::op_e      op_q;
  logic signed [31:0] key_q, v0_q, v1_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      lo_q, hi_q;
  logic               rd_pend_q;
  logic [IW-1:0]      ptr_q;
  logic signed [31:0] rkey_q;
  logic [63:0]        rval_q;
  logic signed [31:0] ks_q;
  logic [63:0]        vs_q;
  logic [IW-1:0]      seg_q;
  logic signed [32:0] dx_q, t_q, dy0_q, dy1_q;
  logic               neg0_q, neg1_q;
  logic [PW-1:0]      p0_q, p1_q, r0_q, r1_q, q0_q, q1_q;
  logic [32:0]        udx_q;
  logic [DCW-1:0]     dcnt_q;
  logic signed [31:0] out0_q, out1_q;
  logic [5:0]         ss_q, se_q;
  logic [skti_pkg::StW-1:0] st_q;

  logic [CW-1:0] mid;
  logic [CW-1:0] gpos;
  logic [CW-1:0] seg_w;
  logic [CW-1:0] cm2;

  assign mid  = lo_q + ((hi_q - lo_q) >> 1);
  assign gpos = lo_q;
  assign cm2  = count_q - CW'(2);
  always_comb begin
    seg_w = (gpos == '0) ? '0 : gpos - CW'(1);
    if (seg_w > cm2) seg_w = cm2;
  end

  assign sts_o.op         = op_q;
  assign sts_o.srch_done  = (lo_q >= hi_q) && !rd_pend_q;
  assign sts_o.full       = (count_q >= CW'(skti_pkg::Capacity));
  assign sts_o.few        = (count_q < CW'(2));
  assign sts_o.shift_done = ((CW'(ptr_q) <= gpos) || (count_q == '0)) && !rd_pend_q;
  assign sts_o.div_done   = (dcnt_q == '0);

  // Memory ports: one write, one registered read.
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wk;
  logic [63:0]   mem_wv;
  logic          mem_re;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_q;
    mem_wk = rkey_q;
    mem_wv = rval_q;
    mem_re = 1'b0;
    mem_ra = mid[IW-1:0];
    if (cmd_i.srch_step && !(lo_q >= hi_q) && !rd_pend_q) mem_re = 1'b1;
    if (cmd_i.shift_wr) begin
      mem_ra = ptr_q - IW'(1);
      mem_re = 1'b1;
      mem_we = rd_pend_q;
    end
    if (cmd_i.ins_wr) begin
      mem_we = 1'b1;
      mem_wa = gpos[IW-1:0];
      mem_wk = key_q;
      mem_wv = {v1_q, v0_q};
    end
    if (cmd_i.rd_s) begin
      mem_re = 1'b1;
      mem_ra = seg_w[IW-1:0];
    end
    if (cmd_i.rd_e) begin
      mem_re = 1'b1;
      mem_ra = seg_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wk;
      val_mem[mem_wa] <= mem_wv;
    end
    if (mem_re) begin
      rkey_q <= key_mem[mem_ra];
      rval_q <= val_mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_pend_q <= 1'b0;
      dcnt_q    <= '0;
      op_q      <= skti_pkg::OP_NONE;
    end else begin
      if (cmd_i.load) begin
        op_q <= skti_pkg::op_e'(op_i);
      end
      if (cmd_i.clear) count_q <= '0;
      if (cmd_i.srch_start) begin
        rd_pend_q <= 1'b0;
      end
      if (cmd_i.srch_step) begin
        if (rd_pend_q) begin
          rd_pend_q <= 1'b0;
        end else if (lo_q < hi_q) begin
          rd_pend_q <= 1'b1;
        end
      end
      if (cmd_i.shift_wr) rd_pend_q <= !rd_pend_q && !sts_o.shift_done;
      // The count steps when the result is built, so the status still sees the old count.
      if (cmd_i.fin && op_q == skti_pkg::OP_INSERT && !sts_o.full) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.div_start) dcnt_q <= DCW'(PW);
      else if (cmd_i.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - DCW'(1);
    end
  end

  logic [PW-1:0] rs0, rs1;
  logic [PW:0]   tr0, tr1;
  logic [PW-1:0] qq0, qq1;
  logic signed [PW+1:0] sum0, sum1;

  function automatic logic signed [31:0] sat(input logic signed [PW+1:0] v);
    logic signed [31:0] r;
    if (v > (PW+2)'(signed'(32'sh7fffffff))) r = 32'sh7fffffff;
    else if (v < (PW+2)'(signed'(-33'sd2147483648))) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  always_comb begin
    tr0 = {r0_q, p0_q[PW-1]} - {1'b0, {(PW-33){1'b0}}, udx_q};
    tr1 = {r1_q, p1_q[PW-1]} - {1'b0, {(PW-33){1'b0}}, udx_q};
    rs0 = {r0_q[PW-2:0], 1'b0};
    rs1 = {r1_q[PW-2:0], 1'b0};
    qq0 = (({r0_q, 1'b0} >= {1'b0, {(PW-33){1'b0}}, udx_q}) && (udx_q != '0))
          ? q0_q + PW'(1) : q0_q;
    qq1 = (({r1_q, 1'b0} >= {1'b0, {(PW-33){1'b0}}, udx_q}) && (udx_q != '0))
          ? q1_q + PW'(1) : q1_q;
    sum0 = neg0_q ? (PW+2)'(signed'(vs_q[31:0])) - signed'({2'b00, qq0})
                  : (PW+2)'(signed'(vs_q[31:0])) + signed'({2'b00, qq0});
    sum1 = neg1_q ? (PW+2)'(signed'(vs_q[63:32])) - signed'({2'b00, qq1})
                  : (PW+2)'(signed'(vs_q[63:32])) + signed'({2'b00, qq1});
  end

  logic [32:0] ady0, ady1, at;
  assign ady0 = dy0_q[32] ? 33'(-dy0_q) : 33'(dy0_q);
  assign ady1 = dy1_q[32] ? 33'(-dy1_q) : 33'(dy1_q);
  assign at   = t_q[32]   ? 33'(-t_q)   : 33'(t_q);

  logic signed [32:0] dxr;
  assign dxr = 33'(rkey_q) - 33'(ks_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
      v0_q  <= value0_i;
      v1_q  <= value1_i;
    end
    if (cmd_i.srch_start) begin
      lo_q <= '0;
      hi_q <= count_q;
    end
    if (cmd_i.srch_step && rd_pend_q) begin
      if (rkey_q > key_q) hi_q <= mid;
      else lo_q <= mid + CW'(1);
    end
    if (cmd_i.srch_step) ptr_q <= count_q[IW-1:0];
    if (cmd_i.shift_wr && rd_pend_q) ptr_q <= ptr_q - IW'(1);
    if (cmd_i.rd_s) seg_q <= seg_w[IW-1:0];
    if (cmd_i.rd_e) begin
      ks_q <= rkey_q;
      vs_q <= rval_q;
    end
    if (cmd_i.setup) begin
      dx_q  <= (dxr < 33'sd1) ? 33'sd1 : dxr;
      t_q   <= 33'(key_q) - 33'(ks_q);
      dy0_q <= 33'(signed'(rval_q[31:0])) - 33'(signed'(vs_q[31:0]));
      dy1_q <= 33'(signed'(rval_q[63:32])) - 33'(signed'(vs_q[63:32]));
    end
    if (cmd_i.mul) begin
      p0_q   <= PW'(ady0) * PW'(at);
      p1_q   <= PW'(ady1) * PW'(at);
      neg0_q <= dy0_q[32] ^ t_q[32];
      neg1_q <= dy1_q[32] ^ t_q[32];
      udx_q  <= dx_q[32:0];
      r0_q   <= '0;
      r1_q   <= '0;
      q0_q   <= '0;
      q1_q   <= '0;
    end
    if (cmd_i.div_step && dcnt_q != '0) begin
      p0_q <= {p0_q[PW-2:0], 1'b0};
      p1_q <= {p1_q[PW-2:0], 1'b0};
      if (!tr0[PW]) begin
        r0_q <= tr0[PW-1:0];
        q0_q <= {q0_q[PW-2:0], 1'b1};
      end else begin
        r0_q <= rs0 | PW'(p0_q[PW-1]);
        q0_q <= {q0_q[PW-2:0], 1'b0};
      end
      if (!tr1[PW]) begin
        r1_q <= tr1[PW-1:0];
        q1_q <= {q1_q[PW-2:0], 1'b1};
      end else begin
        r1_q <= rs1 | PW'(p1_q[PW-1]);
        q1_q <= {q1_q[PW-2:0], 1'b0};
      end
    end
    if (cmd_i.fin) begin
      if (op_q == skti_pkg::OP_PREDICT && !sts_o.few) begin
        out0_q <= sat(sum0);
        out1_q <= sat(sum1);
        ss_q   <= 6'(seg_q);
        se_q   <= 6'(seg_q + IW'(1));
      end else begin
        out0_q <= '0;
        out1_q <= '0;
        ss_q   <= (op_q == skti_pkg::OP_INSERT) ? 6'(gpos) : '0;
        se_q   <= '0;
      end
      if (op_q == skti_pkg::OP_INSERT && sts_o.full) st_q <= skti_pkg::ST_FULL;
      else if (op_q == skti_pkg::OP_PREDICT && sts_o.few) st_q <= skti_pkg::ST_FEW;
      else st_q <= skti_pkg::ST_OK;
    end
  end

  assign out0_o       = out0_q;
  assign out1_o       = out1_q;
  assign seg_start_o  = ss_q;
  assign seg_end_o    = se_q;
  assign status_o     = st_q;
  assign knot_count_o = 7'(count_q);

endmodule

>>> hw/rtl/sorted_knot_table_interpolator_top.sv
// Top level: stream wrapper joining the knot table controller and datapath.
// The block keeps up to 64 knots sorted by key and answers one result word per input word.
// Items are handled one at a time: no input word is taken until the last result word
// has been taken. A clear, an unused code or a predict with fewer than two knots skips the
// binary search and goes straight to building the result. The search makes at most as many
// halvings as the knot count has bits (7 at 64 knots), each a registered read of the knot
// memory and a compare. An insert then moves the knots from the insert position up by one
// place, one at a time through the single write port of the knot memory, and writes the new
// knot; a refused insert goes from the search straight to the result. A predict takes the
// search, two knot reads and a bit-serial divider of 66 steps. The result word waits in the
// output register until taken. The knot memories need no clearing after reset: only entries
// below the knot count are ever used.
module sorted_knot_table_interpolator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // op[1:0], key[33:2], value0[65:34], value1[97:66]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata   // out0, out1, seg_start, seg_end, status, knot_count
);

  skti_pkg::cmd_t cmd;
  skti_pkg::sts_t sts;
  logic signed [31:0] out0, out1;
  logic [5:0] seg_start, seg_end;
  logic [1:0] status;
  logic [6:0] knot_count;

  skti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  skti_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tdata[1:0]),
    .key_i        (s_axis_tdata[33:2]),
    .value0_i     (s_axis_tdata[65:34]),
    .value1_i     (s_axis_tdata[97:66]),
    .out0_o       (out0),
    .out1_o       (out1),
    .seg_start_o  (seg_start),
    .seg_end_o    (seg_end),
    .status_o     (status),
    .knot_count_o (knot_count)
  );

  assign m_axis_tdata = {3'b000, knot_count, status, seg_end, seg_start, out1, out0};

endmodule
